### sv/wwr_pkg.sv
// shared types, constants and helpers for the whole word replace stream
`timescale 1ns / 1ps

package wwr_pkg;

  localparam int unsigned WORD_MAX_DEF = 8;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned SEQ_W        = 4;
  localparam int unsigned REPL_MAX     = 8;
  localparam int unsigned REPL_IDX_W   = 3;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 64;

  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2c;
  localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_TEXT       = 8'd0,
    CFG_PATTERN_LENGTH     = 8'd1,
    CFG_REPLACEMENT_TEXT   = 8'd2,
    CFG_REPLACEMENT_LENGTH = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    FLUSH_NONE,
    FLUSH_BUFFER,
    FLUSH_WORD
  } flush_kind_e;

  typedef struct packed {
    logic accept;
    logic decide;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_room;
    logic seq_empty;
    logic emit_last;
  } dp_status_t;

  function automatic logic is_delim(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_PERIOD) || (c == CHAR_COMMA) ||
           (c == CHAR_LPAREN) || (c == CHAR_RPAREN);
  endfunction

endpackage

### sv/wwr_stream_if.sv
// stream and configuration channel interfaces
`timescale 1ns / 1ps

interface wwr_in_if;
  logic                       valid;
  logic                       ready;
  logic [wwr_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;
  modport source (output valid, in_char, in_last, input ready);
  modport sink (input valid, in_char, in_last, output ready);
endinterface

interface wwr_out_if;
  logic                       valid;
  logic                       ready;
  logic [wwr_pkg::CHAR_W-1:0] out_char;
  logic                       run_last;
  modport source (output valid, out_char, run_last, input ready);
  modport sink (input valid, out_char, run_last, output ready);
endinterface

interface wwr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wwr_pkg::CFG_IDX_W-1:0]  index;
  logic [wwr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/wwr_ctrl.sv
// controller state machine: accept, decide, emit sequencing
`timescale 1ns / 1ps

module wwr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wwr_pkg::dp_status_t status_i,
  output wwr_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_ready_o
);

  wwr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o    = (state_q == wwr_pkg::ST_IDLE);
    cmd_o.accept  = in_ready_o && status_i.in_valid;
    cmd_o.decide  = (state_q == wwr_pkg::ST_DECIDE);
    cmd_o.emit    = (state_q == wwr_pkg::ST_EMIT) && status_i.out_room;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wwr_pkg::ST_IDLE: begin
        if (status_i.in_valid) state_d = wwr_pkg::ST_DECIDE;
      end
      wwr_pkg::ST_DECIDE: begin
        state_d = status_i.seq_empty ? wwr_pkg::ST_IDLE : wwr_pkg::ST_EMIT;
      end
      wwr_pkg::ST_EMIT: begin
        if (status_i.out_room && status_i.emit_last) state_d = wwr_pkg::ST_IDLE;
      end
      default: begin
        state_d = wwr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/wwr_datapath.sv
// datapath: config registers, word buffer, match compare and output register
`timescale 1ns / 1ps

module wwr_datapath #(
  parameter int unsigned WORD_MAX = wwr_pkg::WORD_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wwr_pkg::ctrl_cmd_t             cmd_i,
  output wwr_pkg::dp_status_t            status_o,
  input  logic                           in_valid_i,
  input  logic [wwr_pkg::CHAR_W-1:0]     in_char_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wwr_pkg::CHAR_W-1:0]     out_char_o,
  output logic                           run_last_o,
  input  logic                           cfg_valid_i,
  input  logic [wwr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wwr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CHAR_W = wwr_pkg::CHAR_W;
  localparam int unsigned LEN_W  = wwr_pkg::LEN_W;
  localparam int unsigned SEQ_W  = wwr_pkg::SEQ_W;
  localparam int unsigned RIDX_W = wwr_pkg::REPL_IDX_W;
  localparam int unsigned IDX_W  = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int unsigned CNT_W  = $clog2(WORD_MAX + 1);

  // configuration
  logic [wwr_pkg::CFG_DATA_W-1:0] pat_text_q, rep_text_q;
  logic [LEN_W-1:0]               pat_len_q, rep_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_text_q <= '0;
      pat_len_q  <= LEN_W'(1);
      rep_text_q <= '0;
      rep_len_q  <= '0;
    end else if (cfg_valid_i) begin
      case (wwr_pkg::cfg_reg_e'(cfg_index_i))
        wwr_pkg::CFG_PATTERN_TEXT:       pat_text_q <= cfg_data_i;
        wwr_pkg::CFG_PATTERN_LENGTH:     pat_len_q  <= cfg_data_i[LEN_W-1:0];
        wwr_pkg::CFG_REPLACEMENT_TEXT:   rep_text_q <= cfg_data_i;
        wwr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] plen_eff, rlen_eff;

  always_comb begin
    if (pat_len_q == '0) begin
      plen_eff = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(WORD_MAX)) begin
      plen_eff = LEN_W'(WORD_MAX);
    end else begin
      plen_eff = pat_len_q;
    end
    rlen_eff = (rep_len_q > LEN_W'(wwr_pkg::REPL_MAX)) ? LEN_W'(wwr_pkg::REPL_MAX) : rep_len_q;
  end

  // word state
  logic [CHAR_W-1:0]    buf_q [WORD_MAX];
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 pass_q, pass_d;
  logic                 buf_we;

  // per-request sequence description
  logic [CHAR_W-1:0]    tail_char_q, tail_char_d;
  logic                 tail_en_q, tail_en_d;
  wwr_pkg::flush_kind_e kind_q, kind_d;
  logic [CNT_W-1:0]     word_len_q, word_len_d;
  logic [LEN_W-1:0]     head_len_q, head_len_c;
  logic                 head_repl_q;
  logic [SEQ_W-1:0]     total_q, total_c;
  logic [SEQ_W-1:0]     idx_q;

  logic delim, is_long;

  always_comb begin
    delim   = wwr_pkg::is_delim(in_char_i);
    is_long = (LEN_W'(count_q) >= plen_eff);

    count_d     = count_q;
    pass_d      = pass_q;
    buf_we      = 1'b0;
    tail_char_d = in_char_i;
    tail_en_d   = 1'b1;
    kind_d      = wwr_pkg::FLUSH_NONE;
    word_len_d  = count_q;

    if (delim) begin
      kind_d  = pass_q ? wwr_pkg::FLUSH_NONE : wwr_pkg::FLUSH_WORD;
      count_d = '0;
      pass_d  = 1'b0;
    end else if (pass_q) begin
      kind_d = wwr_pkg::FLUSH_NONE;
    end else if (is_long) begin
      // word outgrew the pattern: flush it and pass the rest through
      kind_d  = wwr_pkg::FLUSH_BUFFER;
      count_d = '0;
      pass_d  = 1'b1;
    end else begin
      tail_en_d  = 1'b0;
      buf_we     = 1'b1;
      count_d    = count_q + CNT_W'(1);
      word_len_d = count_q + CNT_W'(1);
      kind_d     = in_last_i ? wwr_pkg::FLUSH_WORD : wwr_pkg::FLUSH_NONE;
    end

    if (in_last_i) begin
      count_d = '0;
      pass_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pass_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      count_q <= count_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && buf_we) begin
      buf_q[count_q[IDX_W-1:0]] <= in_char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tail_char_q <= tail_char_d;
      tail_en_q   <= tail_en_d;
      kind_q      <= kind_d;
      word_len_q  <= word_len_d;
    end
  end

  // whole-word compare against the pattern
  logic mismatch, match;

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < WORD_MAX; i++) begin
      if ((CNT_W'(i) < word_len_q) && (buf_q[i] != pat_text_q[CHAR_W*i +: CHAR_W])) begin
        mismatch = 1'b1;
      end
    end
    match = (kind_q == wwr_pkg::FLUSH_WORD) && (LEN_W'(word_len_q) == plen_eff) && !mismatch;

    if (match) begin
      head_len_c = rlen_eff;
    end else if (kind_q != wwr_pkg::FLUSH_NONE) begin
      head_len_c = LEN_W'(word_len_q);
    end else begin
      head_len_c = '0;
    end
    total_c = SEQ_W'(head_len_c) + SEQ_W'(tail_en_q);
  end

  // emission sequencing and output register
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q, emit_char;
  logic              run_last_q;
  logic              emit_last;

  always_comb begin
    if (idx_q < SEQ_W'(head_len_q)) begin
      emit_char = head_repl_q ? rep_text_q[{idx_q[RIDX_W-1:0], 3'b000} +: CHAR_W]
                              : buf_q[idx_q[IDX_W-1:0]];
    end else begin
      emit_char = tail_char_q;
    end
    emit_last = (idx_q == total_q - SEQ_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      head_len_q  <= head_len_c;
      head_repl_q <= match;
      total_q     <= total_c;
      idx_q       <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      run_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

  always_comb begin
    status_o.in_valid  = in_valid_i;
    status_o.out_room  = !out_valid_q || out_ready_i;
    status_o.seq_empty = (total_c == '0);
    status_o.emit_last = emit_last;
  end

endmodule

### sv/whole_word_replace_stream.sv
// top level: whole word find and replace over a byte stream
// an accepted byte goes through the decide state, then one output byte per cycle while the output register has room
// a new byte is not accepted until the previous one has been decided and all of its result bytes emitted
// throughput is set by the single output register, one result byte per cycle while out_o.ready drains it
// next request is taken while the final result byte still waits in the output register
// reset clears word state, handshake state and config registers; the word buffer is not cleared
`timescale 1ns / 1ps

module whole_word_replace_stream #(
  parameter int unsigned WORD_MAX = wwr_pkg::WORD_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wwr_in_if.sink     in_i,
  wwr_out_if.source  out_o,
  wwr_cfg_if.sink    cfg_i
);

  wwr_pkg::ctrl_cmd_t  cmd;
  wwr_pkg::dp_status_t status;
  logic                in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  wwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  wwr_datapath #(
    .WORD_MAX (WORD_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_i.valid),
    .in_char_i   (in_i.in_char),
    .in_last_i   (in_i.in_last),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .run_last_o  (out_o.run_last),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data)
  );

endmodule
